### design/vsa_pkg.sv
`default_nettype none
package vsa_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] CMD_ALLOC    = 3'd0;
    localparam logic [2:0] CMD_PLAY     = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_RESUME   = 3'd3;
    localparam logic [2:0] CMD_LOOP     = 3'd4;
    localparam logic [2:0] CMD_STATUS   = 3'd5;
    localparam logic [2:0] CMD_FINISHED = 3'd6;
    localparam logic [2:0] CMD_UNDEF    = 3'd7;

    localparam logic [31:0] STAMP_NONE = 32'hFFFF_FFFF;

    // classified request handed from front to back
    typedef struct packed {
        logic [2:0]  command;
        logic        bad;
        logic        loop_on;
        logic [31:0] voice_id;
        logic [7:0]  sound_number;
        logic [31:0] time_now;
    } vsa_req_t;

    typedef struct packed {
        logic [31:0] result_id;
        logic [4:0]  slot_index;
        logic        status_code;
        logic        is_playing;
        logic        evicted;
    } vsa_rsp_t;

endpackage
`default_nettype wire

### design/vsa_front.sv
`default_nettype none
module vsa_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    output logic                full,
    input  wire [2:0]           command,
    input  wire [31:0]          voice_id,
    input  wire [7:0]           sound_number,
    input  wire [15:0]          loop_setting,
    input  wire [31:0]          time_now,
    output logic                req_valid,
    output vsa_pkg::vsa_req_t   req_data,
    input  wire                 req_take
);
    import vsa_pkg::*;

    vsa_req_t     q_reg [QUEUE_DEPTH];
    logic         wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         do_push, do_pop;
    vsa_req_t     cls;

    // classify the incoming request
    always_comb
    begin
        cls.command      = command;
        cls.bad          = (command == CMD_UNDEF);
        cls.loop_on      = (loop_setting != 16'd1);
        cls.voice_id     = voice_id;
        cls.sound_number = sound_number;
        cls.time_now     = time_now;
    end

    assign full      = (cnt_reg == 2'(QUEUE_DEPTH));
    assign do_push   = push && !full;
    assign req_valid = (cnt_reg != 2'd0);
    assign do_pop    = req_valid && req_take;
    assign req_data  = q_reg[rp_reg];

    // queue pointers
    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wp_reg] <= cls;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !do_pop |=> full) else $error("queue lost an entry");
    a_take_dec: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && !do_push |=> cnt_reg == $past(cnt_reg) - 2'd1)
        else $error("queue count mismatch");

endmodule
`default_nettype wire

### design/vsa_back.sv
`default_nettype none
module vsa_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    input  vsa_pkg::vsa_req_t   req_data,
    output logic                req_take,
    output logic                empty,
    input  wire                 pop,
    output vsa_pkg::vsa_rsp_t   rsp
);
    import vsa_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [NUM_SLOTS-1:0] used_reg, used_next;
    logic [NUM_SLOTS-1:0] loop_reg, loop_next;
    logic [NUM_SLOTS-1:0] act_reg, act_next;
    logic [31:0]          ident_reg [NUM_SLOTS];
    logic [31:0]          stamp_reg [NUM_SLOTS];
    logic [7:0]           src_reg   [NUM_SLOTS];
    logic [31:0]          nid_reg, nid_next;

    logic [1:0]           st_reg, st_next;
    vsa_req_t             cur_reg, cur_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    // best candidates: empty, not playing, not looping, any
    logic                 fe_reg, fe_next;
    logic [SLOT_W-1:0]    ie_reg, ie_next;
    logic [31:0]          b0_reg, b0_next, b1_reg, b1_next, b2_reg, b2_next;
    logic [SLOT_W-1:0]    i0_reg, i0_next, i1_reg, i1_next, i2_reg, i2_next;
    logic                 f0_reg, f0_next, f1_reg, f1_next, f2_reg, f2_next;
    logic                 hit_reg, hit_next;
    logic [SLOT_W-1:0]    hi_reg, hi_next;
    logic                 out_reg, out_next;
    vsa_rsp_t             rsp_reg, rsp_next;

    logic [SLOT_W-1:0]    ci;
    logic [31:0]          cs;
    logic                 wr_en;
    logic [SLOT_W-1:0]    wr_idx;
    logic                 fnd;
    logic [SLOT_W-1:0]    sel;
    logic                 is_alloc;

    assign ci       = idx_reg[SLOT_W-1:0];
    assign cs       = stamp_reg[ci];
    assign req_take = (st_reg == ST_IDLE) && !out_reg;
    assign empty    = !out_reg;
    assign rsp      = rsp_reg;
    assign is_alloc = (cur_reg.command == CMD_ALLOC);

    // pick the allocation slot from the scan results, or the matching slot otherwise
    always_comb
    begin
        fnd = 1'b1;
        sel = ie_reg;
        if (fe_reg)
            sel = ie_reg;
        else if (f0_reg)
            sel = i0_reg;
        else if (f1_reg)
            sel = i1_reg;
        else if (f2_reg)
            sel = i2_reg;
        else
            fnd = 1'b0;
        if (!is_alloc)
        begin
            fnd = hit_reg && !cur_reg.bad;
            sel = hi_reg;
        end
    end

    // sequencer: one slot per cycle, then write-back
    always_comb
    begin
        st_next  = st_reg;
        cur_next = cur_reg;
        idx_next = idx_reg;
        fe_next = fe_reg; ie_next = ie_reg;
        b0_next = b0_reg; i0_next = i0_reg; f0_next = f0_reg;
        b1_next = b1_reg; i1_next = i1_reg; f1_next = f1_reg;
        b2_next = b2_reg; i2_next = i2_reg; f2_next = f2_reg;
        hit_next = hit_reg; hi_next = hi_reg;
        used_next = used_reg; loop_next = loop_reg; act_next = act_reg;
        nid_next = nid_reg;
        out_next = out_reg;
        rsp_next = rsp_reg;
        wr_en    = 1'b0;
        wr_idx   = sel;
        if (out_reg && pop)
            out_next = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (req_valid && req_take)
                begin
                    cur_next = req_data;
                    idx_next = '0;
                    fe_next = 1'b0; f0_next = 1'b0; f1_next = 1'b0; f2_next = 1'b0;
                    b0_next = STAMP_NONE; b1_next = STAMP_NONE; b2_next = STAMP_NONE;
                    hit_next = 1'b0;
                    st_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!used_reg[ci] && !fe_reg)
                begin
                    fe_next = 1'b1;
                    ie_next = ci;
                end
                if (!act_reg[ci] && cs < b0_reg)
                begin
                    b0_next = cs; i0_next = ci; f0_next = 1'b1;
                end
                if (!loop_reg[ci] && cs < b1_reg)
                begin
                    b1_next = cs; i1_next = ci; f1_next = 1'b1;
                end
                if (cs < b2_reg)
                begin
                    b2_next = cs; i2_next = ci; f2_next = 1'b1;
                end
                if (used_reg[ci] && ident_reg[ci] == cur_reg.voice_id && !hit_reg)
                begin
                    hit_next = 1'b1;
                    hi_next  = ci;
                end
                idx_next = idx_reg + CNT_W'(1);
                if (idx_reg == CNT_W'(NUM_SLOTS - 1))
                    st_next = ST_DONE;
            end
            ST_DONE:
            begin
                rsp_next = '0;
                rsp_next.status_code = 1'b1;
                if (fnd)
                begin
                    rsp_next.status_code = 1'b0;
                    rsp_next.slot_index  = 5'(sel);
                    if (is_alloc)
                    begin
                        nid_next = nid_reg + 32'd1;
                        rsp_next.result_id = nid_reg + 32'd1;
                        rsp_next.evicted   = used_reg[sel];
                        used_next[sel] = 1'b1;
                        act_next[sel]  = 1'b0;
                        loop_next[sel] = 1'b0;
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        case (cur_reg.command)
                            CMD_PLAY, CMD_RESUME:
                            begin
                                act_next[sel] = 1'b1;
                                wr_en = 1'b1;
                            end
                            CMD_STOP, CMD_FINISHED: act_next[sel] = 1'b0;
                            CMD_LOOP: loop_next[sel] = cur_reg.loop_on;
                            default: ;
                        endcase
                        rsp_next.is_playing = act_next[sel];
                    end
                end
                out_next = 1'b1;
                st_next  = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            out_reg  <= 1'b0;
            used_reg <= '0;
            loop_reg <= '0;
            act_reg  <= '0;
            nid_reg  <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            out_reg  <= out_next;
            used_reg <= used_next;
            loop_reg <= loop_next;
            act_reg  <= act_next;
            nid_reg  <= nid_next;
        end
    end

    // slot payload tables, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                ident_reg[k] <= '0;
                stamp_reg[k] <= '0;
                src_reg[k]   <= '0;
            end
        end
        else if (wr_en)
        begin
            stamp_reg[wr_idx] <= cur_reg.time_now;
            if (is_alloc)
            begin
                ident_reg[wr_idx] <= nid_reg + 32'd1;
                src_reg[wr_idx]   <= cur_reg.sound_number;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        fe_reg <= fe_next; ie_reg <= ie_next;
        b0_reg <= b0_next; i0_reg <= i0_next; f0_reg <= f0_next;
        b1_reg <= b1_next; i1_reg <= i1_next; f1_reg <= f1_next;
        b2_reg <= b2_next; i2_reg <= i2_next; f2_reg <= f2_next;
        hit_reg <= hit_next; hi_reg <= hi_next;
        rsp_reg <= rsp_next;
    end

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != ST_IDLE |-> !req_take) else $error("take while busy");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_DONE |=> out_reg) else $error("result not posted");
    a_alloc_used: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_DONE && is_alloc && fnd |=> used_reg[$past(sel)])
        else $error("allocated slot not marked");

endmodule
`default_nettype wire

### design/voice_slot_allocator.sv
// channel  | direction | handshake   | fields
// request  | in        | push / full | command voice_id sound_number loop_setting time_now
// result   | out       | pop / empty | result_id slot_index status_code is_playing evicted
// each request passes through the back end in order:
// set-up, one slot compared per cycle in the scan loop, then write-back
// a two-entry queue lets requests land while the back end is scanning
// a result waits in its register until popped; the back end takes the
// next request only once the result has been popped
// rst_n clears every slot table and the identifier counter at once
`default_nettype none
module voice_slot_allocator (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         push,
    output logic        full,
    input  wire [2:0]   command,
    input  wire [31:0]  voice_id,
    input  wire [7:0]   sound_number,
    input  wire [15:0]  loop_setting,
    input  wire [31:0]  time_now,
    output logic        empty,
    input  wire         pop,
    output logic [31:0] result_id,
    output logic [4:0]  slot_index,
    output logic        status_code,
    output logic        is_playing,
    output logic        evicted
);
    import vsa_pkg::*;

    logic     req_valid, req_take;
    vsa_req_t req_data;
    vsa_rsp_t rsp;

    // front: accept and classify
    vsa_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .command(command), .voice_id(voice_id), .sound_number(sound_number),
        .loop_setting(loop_setting), .time_now(time_now),
        .req_valid(req_valid), .req_data(req_data), .req_take(req_take)
    );

    // back: scan and update the slot table
    vsa_back u_back (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_data(req_data),
        .req_take(req_take), .empty(empty), .pop(pop), .rsp(rsp)
    );

    assign result_id   = rsp.result_id;
    assign slot_index  = rsp.slot_index;
    assign status_code = rsp.status_code;
    assign is_playing  = rsp.is_playing;
    assign evicted     = rsp.evicted;

endmodule
`default_nettype wire
